// ===== hw/rtl/cfe_pkg.sv =====
// shared types and constants for the continued fraction expansion block
// no dependencies; imported by cfe_ctrl, cfe_dpath and continued_fraction_expansion
`timescale 1ns / 1ps

package cfe_pkg;

  localparam int unsigned WIDTH       = 32;
  localparam int unsigned MAX_RESULTS = 48;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RESULTS - 1);

  typedef struct packed {
    logic signed [WIDTH-1:0] numerator;
    logic signed [WIDTH-1:0] denominator;
  } cfe_in_t;

  typedef struct packed {
    logic signed [WIDTH-1:0] term;
    logic                    last;
    logic                    error;
  } cfe_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic shift;
    logic step;
    logic finish;
  } cfe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic den_zero;
    logic can_shift;
    logic step_last;
    logic term_last;
  } cfe_sts_t;

endpackage

// ===== hw/rtl/continued_fraction_expansion.sv =====
// latency: a zero denominator gives its error result in the cycle after the start transfer.
// otherwise each term runs align, subtract and finish steps in the one-bit-per-cycle
// shift-subtract divider; a term shows in the cycle after its finish step
// throughput: one item at a time, the next start transfer is taken only when busy is low
// (a zero denominator never raises busy); busy drops in the cycle the last term is shown
// reset: synchronous active-high rst idles the sequencer and drops result_valid; no receiver stall
`timescale 1ns / 1ps

module continued_fraction_expansion (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cfe_pkg::cfe_in_t operands,
  output cfe_pkg::cfe_out_t result,
  output logic             result_valid
);
  import cfe_pkg::*;

  // command and status between the sequencer and the datapath
  cfe_cmd_t cmd;
  cfe_sts_t sts;

  // sequencer: idle -> align divisor -> shift-subtract -> finish term -> align ...
  cfe_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath: magnitudes, divider registers, term encoding and the result register
  cfe_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .operands     (operands),
    .cmd          (cmd),
    .sts          (sts),
    .result       (result),
    .result_valid (result_valid)
  );

`ifndef SYNTHESIS
  // a result only follows a transfer in or work in progress
  a_valid_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy || start))
    else $error("result without a preceding transfer or active work");

  // error results carry a zero term and close the expansion
  a_error_form: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.error) |-> (result.last && (result.term == '0)))
    else $error("malformed error result");

  // after the final term the block is free again
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> !busy)
    else $error("busy still high on the final term");

  // a zero denominator is answered in the next cycle
  a_zero_den: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operands.denominator == '0)) |=> (result_valid && result.error))
    else $error("zero denominator not flagged");
`endif

endmodule

// ===== hw/rtl/cfe_ctrl.sv =====
// sequencer for the euclid loop: load, align divisor, shift-subtract, finish term
// depends on cfe_pkg
`timescale 1ns / 1ps

module cfe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  cfe_pkg::cfe_sts_t sts,
  output cfe_pkg::cfe_cmd_t cmd,
  output logic              busy
);
  import cfe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ALIGN  = 4'b0010,
    S_DIVIDE = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (!sts.den_zero) state_next = S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (sts.can_shift) cmd.shift = 1'b1;
        else               state_next = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.step = 1'b1;
        if (sts.step_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = sts.term_last ? S_IDLE : S_ALIGN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== hw/rtl/cfe_dpath.sv =====
// datapath: operand magnitudes, shift-subtract divider, term encoding, result register
// depends on cfe_pkg
`timescale 1ns / 1ps

module cfe_dpath (
  input  logic              clk,
  input  logic              rst,
  input  cfe_pkg::cfe_in_t  operands,
  input  cfe_pkg::cfe_cmd_t cmd,
  output cfe_pkg::cfe_sts_t sts,
  output cfe_pkg::cfe_out_t result,
  output logic              result_valid
);
  import cfe_pkg::*;

  localparam logic [WIDTH-1:0] POS_MAX = {1'b0, {(WIDTH-1){1'b1}}};
  localparam logic [WIDTH-1:0] ONE     = WIDTH'(1);

  logic [WIDTH-1:0] rem, dvs, dsh, quo, bitm;
  logic             neg, first;
  logic [CNT_W-1:0] cnt;

  logic             num_neg, den_neg;
  logic [WIDTH-1:0] num_mag, den_mag;
  logic [WIDTH-1:0] term_val, b_new;
  logic             rem_zero, last_val;

  assign num_neg = operands.numerator[WIDTH-1];
  assign den_neg = operands.denominator[WIDTH-1];
  assign num_mag = num_neg ? (WIDTH'(0) - operands.numerator) : operands.numerator;
  assign den_mag = den_neg ? (WIDTH'(0) - operands.denominator) : operands.denominator;

  assign rem_zero = (rem == '0);
  assign last_val = rem_zero || (cnt == CNT_LAST);

  // first term is floor(n/d); a negative inexact quotient rounds down and flips the remainder
  always_comb begin
    b_new = rem;
    if (first && neg) begin
      if (rem_zero) begin
        term_val = WIDTH'(0) - quo;
      end else begin
        term_val = ~quo;
        b_new    = dvs - rem;
      end
    end else begin
      term_val = quo[WIDTH-1] ? POS_MAX : quo;
    end
  end

  assign sts.den_zero  = (operands.denominator == '0);
  assign sts.can_shift = ({dsh, 1'b0} <= {1'b0, rem});
  assign sts.step_last = bitm[0];
  assign sts.term_last = last_val;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem   <= num_mag;
      dvs   <= den_mag;
      dsh   <= den_mag;
      bitm  <= ONE;
      quo   <= '0;
      first <= 1'b1;
      cnt   <= '0;
      neg   <= (num_neg != den_neg) && (num_mag != '0);
    end else if (cmd.shift) begin
      dsh  <= {dsh[WIDTH-2:0], 1'b0};
      bitm <= {bitm[WIDTH-2:0], 1'b0};
    end else if (cmd.step) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= quo | bitm;
      end
      dsh  <= {1'b0, dsh[WIDTH-1:1]};
      bitm <= {1'b0, bitm[WIDTH-1:1]};
    end else if (cmd.finish) begin
      rem   <= dvs;
      dvs   <= b_new;
      dsh   <= b_new;
      bitm  <= ONE;
      quo   <= '0;
      first <= 1'b0;
      cnt   <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.load && sts.den_zero) || cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && sts.den_zero) begin
      result.term  <= '0;
      result.last  <= 1'b1;
      result.error <= 1'b1;
    end else if (cmd.finish) begin
      result.term  <= term_val;
      result.last  <= last_val;
      result.error <= 1'b0;
    end
  end

endmodule

// ===== verif/continued_fraction_expansion_tb.sv =====
// self-checking testbench for continued_fraction_expansion: drives numerator/denominator
// transfers and checks every emitted term against an in-bench euclid expansion
// depends on cfe_pkg (operand and result structs, WIDTH, MAX_RESULTS)
`timescale 1ns / 1ps

module continued_fraction_expansion_tb;
  import cfe_pkg::*;

  localparam int unsigned W = WIDTH;
  // longest stretch without any transfer or result: a term with a full-width quotient
  // and the short sender gaps stay far below it
  localparam int unsigned STALL_LIMIT = 4000;
  // cycles to sit after the last expected term, covers a full-width term
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned PHASE_ITEMS = 134;

  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

  // expected terms of every accepted operand pair, oldest first
  class cf_scoreboard;
    cfe_out_t    pending_terms[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // a positive term magnitude of 2^(W-1) does not fit, it clips to the max
    function logic [W-1:0] clip_pos(logic [W-1:0] mag);
      return (mag > MOST_POS) ? MOST_POS : mag;
    endfunction

    // expand an accepted operand pair into its canonical term list
    function void expand_transfer(cfe_in_t item);
      logic [W-1:0] an, ad, q, r, a, b, t, nr, first;
      logic         nneg, dneg, neg;
      int unsigned  count;
      an   = item.numerator;
      ad   = item.denominator;
      nneg = an[W-1];
      dneg = ad[W-1];
      if (nneg) an = -an;
      if (dneg) ad = -ad;
      if (ad == '0) begin
        pending_terms.push_back('{term: '0, last: 1'b1, error: 1'b1});
        return;
      end
      // a zero numerator has no sign, whatever the denominator says
      neg = (nneg != dneg) && (an != '0);
      q = an / ad;
      r = an % ad;
      if (neg) begin
        // floor rounds away from zero unless the quotient is exact
        if (r == '0) begin
          first = -q;
        end else begin
          first = -(q + 1'b1);
          r = ad - r;
        end
      end else begin
        first = clip_pos(q);
      end
      pending_terms.push_back('{term: first, last: (r == '0), error: 1'b0});
      count = 1;
      a = ad;
      b = r;
      while (b != '0 && count < MAX_RESULTS) begin
        t  = a / b;
        nr = a % b;
        pending_terms.push_back('{term: clip_pos(t),
                                  last: (nr == '0) || (count + 1 >= MAX_RESULTS),
                                  error: 1'b0});
        count++;
        a = b;
        b = nr;
      end
    endfunction

    function void check_term(cfe_out_t got);
      cfe_out_t want;
      if (pending_terms.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected term %0d last %0b error %0b", got.term, got.last, got.error);
        return;
      end
      want = pending_terms.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("term mismatch: expected %0d last %0b error %0b, got %0d last %0b error %0b",
                   want.term, want.last, want.error, got.term, got.last, got.error);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  cfe_in_t     operands;
  cfe_out_t    result;
  logic        result_valid;

  cf_scoreboard sb;
  int unsigned  sender_idle_pct;
  int unsigned  quiet_cycles;

  continued_fraction_expansion u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operands     (operands),
    .result       (result),
    .result_valid (result_valid)
  );

  always #2 clk = ~clk;

  // result monitor and stall watchdog; dut outputs are still pre-edge values here
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (result_valid === 1'b1) sb.check_term(result);
      if ((start && !busy) || result_valid === 1'b1) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // one operand transfer: optional idle gap, then hold start until busy is low at an edge
  task automatic send_item(input cfe_in_t item);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    operands <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    // transfer happened at this edge
    sb.expand_transfer(item);
  endtask

  task automatic send_pair(input logic [W-1:0] n, input logic [W-1:0] d);
    send_item('{numerator: n, denominator: d});
  endtask

  // sender holds off until every expected term has shown up, then lets the block settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_terms.size() != 0 || busy) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [W-1:0] pick_extreme();
    case ($urandom_range(0, 5))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return '1;
      3:       return '0;
      4:       return W'(1);
      default: return MOST_NEG + 1'b1;
    endcase
  endfunction

  function automatic cfe_in_t random_item();
    cfe_in_t      it;
    logic [W-1:0] f0, f1, tmp;
    int           v, k;
    it.numerator   = $urandom;
    it.denominator = $urandom;
    case ($urandom_range(0, 9))
      0: it.denominator = '0;
      4: begin
        // small fractions, zero denominator included
        v = $urandom_range(0, 200);
        it.numerator = W'(v - 100);
        v = $urandom_range(0, 64);
        it.denominator = W'(v - 32);
      end
      5: begin
        v = $urandom_range(1, 16);
        it.denominator = ($urandom_range(0, 1) != 0) ? W'(-v) : W'(v);
      end
      6: begin
        // consecutive fibonacci numbers give the longest euclid chains
        f0 = '0;
        f1 = W'(1);
        k = $urandom_range(1, 45);
        for (int i = 0; i < k; i++) begin
          tmp = f0 + f1;
          f0 = f1;
          f1 = tmp;
        end
        it.numerator   = ($urandom_range(0, 1) != 0) ? -f1 : f1;
        it.denominator = ($urandom_range(0, 1) != 0) ? -f0 : f0;
        if ($urandom_range(0, 1) != 0) begin
          tmp = it.numerator;
          it.numerator = it.denominator;
          it.denominator = tmp;
        end
      end
      7: begin
        it.numerator   = pick_extreme();
        it.denominator = pick_extreme();
      end
      8: begin
        // exact quotients of both signs
        v = $urandom_range(1, 1000);
        if ($urandom_range(0, 1) != 0) v = -v;
        k = $urandom_range(0, 200000);
        k = k - 100000;
        it.denominator = W'(v);
        it.numerator   = W'(v * k);
      end
      9: begin
        it.numerator   = $signed(it.numerator) >>> $urandom_range(0, W-1);
        it.denominator = $signed(it.denominator) >>> $urandom_range(0, W-1);
      end
      default: ;
    endcase
    return it;
  endfunction

  initial begin
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    operands = '0;
    sender_idle_pct = 7;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero denominators
    send_pair('0, '0);
    send_pair(W'(5), '0);
    send_pair(MOST_NEG, '0);
    // zero numerator, either denominator sign
    send_pair('0, W'(5));
    send_pair('0, -W'(5));
    // exact quotients, negative ones must not grow an extra term
    send_pair(W'(7), W'(1));
    send_pair(-W'(7), W'(1));
    send_pair(W'(6), -W'(3));
    send_pair(MOST_NEG, W'(1));
    send_pair(MOST_POS, W'(1));
    // saturation of the first term and of a later term
    send_pair(MOST_NEG, '1);
    send_pair('1, MOST_NEG);
    send_pair(W'(1), MOST_NEG);
    // rounding toward minus infinity on inexact negatives
    send_pair(-W'(7), W'(2));
    send_pair('1, W'(2));
    // extremes against each other
    send_pair(MOST_POS, MOST_POS);
    send_pair(MOST_POS, MOST_NEG);
    send_pair(MOST_NEG, MOST_POS);
    send_pair(W'(1), MOST_POS);
    send_pair(W'(355), W'(113));
    // longest chains at this width
    send_pair(W'(1836311903), W'(1134903170));
    send_pair(-W'(1836311903), W'(1134903170));
    send_pair(W'(1134903170), -W'(1836311903));

    for (int i = 0; i < PHASE_ITEMS; i++) send_item(random_item());
    drain();

    // mostly idle sender
    sender_idle_pct = 57;
    for (int i = 0; i < PHASE_ITEMS; i++) send_item(random_item());
    drain();

    // back-to-back transfers
    sender_idle_pct = 0;
    for (int i = 0; i < PHASE_ITEMS; i++) send_item(random_item());
    drain();

    if (sb.mismatches == 0 && sb.pending_terms.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
